// ===== rtl/ps2_mouse_packet_tracker_top_macros.svh =====
// Assertion macros for the PS/2 mouse packet tracker.
`ifndef PS2_MOUSE_PACKET_TRACKER_TOP_MACROS_SVH
`define PS2_MOUSE_PACKET_TRACKER_TOP_MACROS_SVH

`ifndef NO_ASSERTIONS
// Same-cycle implication, disabled during reset.
`define PMPT_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("pmpt same-cycle check failed");
// Next-cycle implication, disabled during reset.
`define PMPT_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("pmpt next-cycle check failed");
`else
`define PMPT_ASSERT_IMP(lbl, ante, cons)
`define PMPT_ASSERT_NXT(lbl, ante, cons)
`endif

`endif

// ===== rtl/pmpt_pkg.sv =====
// Shared constants and types for the PS/2 mouse packet tracker.
package pmpt_pkg;

  localparam int BYTE_W  = 8;
  localparam int COORD_W = 12;
  localparam int DELTA_W = 10;
  localparam int SUM_W   = 14;

  // Header bit positions
  localparam int SYNC_BIT = 3;
  localparam int X_SIGN   = 4;
  localparam int Y_SIGN   = 5;
  localparam int X_OVER   = 6;
  localparam int Y_OVER   = 7;

  localparam logic signed [DELTA_W-1:0] OVER_MAG = 10'sd255;
  localparam logic [COORD_W-1:0] X_MARGIN = 12'd8;
  localparam logic [COORD_W-1:0] Y_MARGIN = 12'd16;

  localparam logic [COORD_W-1:0] WIDTH_RESET  = 12'd640;
  localparam logic [COORD_W-1:0] HEIGHT_RESET = 12'd480;

  // Register indexes
  localparam logic REG_FRAME_WIDTH  = 1'b0;
  localparam logic REG_FRAME_HEIGHT = 1'b1;

  // Packet framing phases
  localparam logic [1:0] PH_FIRST  = 2'd0;
  localparam logic [1:0] PH_SECOND = 2'd1;
  localparam logic [1:0] PH_THIRD  = 2'd2;

  typedef struct packed {
    logic [COORD_W-1:0] cursor_y;
    logic [COORD_W-1:0] cursor_x;
  } result_t;

  // Signed movement of one axis: 9-bit value plus overflow magnitude
  function automatic logic signed [DELTA_W-1:0] axis_delta(
    input logic [BYTE_W-1:0] low_byte,
    input logic              neg,
    input logic              over
  );
    logic signed [DELTA_W-1:0] d;
    d = $signed({neg, neg, low_byte});
    if (over) begin
      d = neg ? (d - OVER_MAG) : (d + OVER_MAG);
    end
    return d;
  endfunction

  // Clamp a signed position to 0..extent-margin, limit saturating at zero
  function automatic logic [COORD_W-1:0] clamp_axis(
    input logic signed [SUM_W-1:0] v,
    input logic [COORD_W-1:0]      extent,
    input logic [COORD_W-1:0]      margin
  );
    logic [COORD_W-1:0] limit;
    limit = (extent >= margin) ? (extent - margin) : '0;
    if (v < 0) begin
      return '0;
    end else if (v > $signed({2'b00, limit})) begin
      return limit;
    end
    return v[COORD_W-1:0];
  endfunction

endpackage

// ===== rtl/ps2_mouse_packet_tracker_top.sv =====
// Top level of the PS/2 mouse packet tracker.
// Frames PS/2 mouse bytes into three-byte packets and tracks a clamped cursor.
// One byte is accepted per cycle while the output is not stalled: each request
// lands in an input register, then the framing phase and cursor update run in
// one pass of add and clamp logic, and the third byte of a packet writes the
// new position into the output register. A byte is taken as a packet header
// only if its bit 3 is set. The input register moves on whenever the output
// register is free or being drained, so a new byte can be accepted while a
// result waits. The user must write frame_width and frame_height through
// the cfg port only while the block is idle; the block does not enforce it.
`include "ps2_mouse_packet_tracker_top_macros.svh"

module ps2_mouse_packet_tracker_top (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] rx_byte
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [23:0] out_tdata,  // [11:0] cursor_x, [23:12] cursor_y
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [11:0] cfg_wdata
);

  logic [pmpt_pkg::COORD_W-1:0] frame_width_r, frame_height_r;

  logic                        in_valid_r;
  logic [pmpt_pkg::BYTE_W-1:0] in_byte_r;

  logic [1:0]                   phase_r, phase_nxt;
  logic [pmpt_pkg::BYTE_W-1:0]  header_r, header_nxt;
  logic [pmpt_pkg::BYTE_W-1:0]  x_move_r, x_move_nxt;
  logic [pmpt_pkg::COORD_W-1:0] pos_x_r, pos_x_nxt;
  logic [pmpt_pkg::COORD_W-1:0] pos_y_r, pos_y_nxt;

  logic                 out_valid_r;
  pmpt_pkg::result_t    out_data_r;

  logic                              has_result;
  logic                              advance;
  logic signed [pmpt_pkg::DELTA_W-1:0] dx, dy;
  logic signed [pmpt_pkg::SUM_W-1:0]   nx, ny;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      frame_width_r  <= pmpt_pkg::WIDTH_RESET;
      frame_height_r <= pmpt_pkg::HEIGHT_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        pmpt_pkg::REG_FRAME_WIDTH:  frame_width_r  <= cfg_wdata;
        pmpt_pkg::REG_FRAME_HEIGHT: frame_height_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // Advance the held byte unless its result would overwrite a waiting one
  assign has_result = in_valid_r && (phase_r == pmpt_pkg::PH_THIRD);
  assign advance    = in_valid_r && (!has_result || !out_valid_r || out_tready);
  assign in_tready  = !in_valid_r || advance;

  // Capture input requests
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_tready) begin
      in_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      in_byte_r <= in_tdata;
    end
  end

  // Decode movement and clamp the new position
  always_comb begin
    dx = pmpt_pkg::axis_delta(x_move_r, header_r[pmpt_pkg::X_SIGN],
                              header_r[pmpt_pkg::X_OVER]);
    dy = pmpt_pkg::axis_delta(in_byte_r, header_r[pmpt_pkg::Y_SIGN],
                              header_r[pmpt_pkg::Y_OVER]);
    nx = $signed({2'b00, pos_x_r}) + pmpt_pkg::SUM_W'(dx);
    ny = $signed({2'b00, pos_y_r}) - pmpt_pkg::SUM_W'(dy);
  end

  // Framing phase and cursor next state
  always_comb begin
    phase_nxt  = phase_r;
    header_nxt = header_r;
    x_move_nxt = x_move_r;
    pos_x_nxt  = pos_x_r;
    pos_y_nxt  = pos_y_r;
    case (phase_r)
      pmpt_pkg::PH_SECOND: begin
        x_move_nxt = in_byte_r;
        phase_nxt  = pmpt_pkg::PH_THIRD;
      end
      pmpt_pkg::PH_THIRD: begin
        phase_nxt = pmpt_pkg::PH_FIRST;
        pos_x_nxt = pmpt_pkg::clamp_axis(nx, frame_width_r, pmpt_pkg::X_MARGIN);
        pos_y_nxt = pmpt_pkg::clamp_axis(ny, frame_height_r, pmpt_pkg::Y_MARGIN);
      end
      default: begin
        // Drop bytes without the sync bit
        if (in_byte_r[pmpt_pkg::SYNC_BIT]) begin
          header_nxt = in_byte_r;
          phase_nxt  = pmpt_pkg::PH_SECOND;
        end else begin
          phase_nxt  = pmpt_pkg::PH_FIRST;
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r  <= pmpt_pkg::PH_FIRST;
      header_r <= '0;
      x_move_r <= '0;
      pos_x_r  <= '0;
      pos_y_r  <= '0;
    end else if (advance) begin
      phase_r  <= phase_nxt;
      header_r <= header_nxt;
      x_move_r <= x_move_nxt;
      pos_x_r  <= pos_x_nxt;
      pos_y_r  <= pos_y_nxt;
    end
  end

  // Output register: load on a completed packet, clear when drained
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance && has_result) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && has_result) begin
      out_data_r.cursor_x <= pos_x_nxt;
      out_data_r.cursor_y <= pos_y_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  // Checks
  `PMPT_ASSERT_NXT(a_third_byte_emits, advance && has_result, out_valid_r)
  `PMPT_ASSERT_IMP(a_out_matches_pos, out_valid_r && !in_valid_r,
                   out_data_r.cursor_x == pos_x_r && out_data_r.cursor_y == pos_y_r)
  `PMPT_ASSERT_NXT(a_stall_holds_pos, out_valid_r && !out_tready,
                   $stable(pos_x_r) && $stable(pos_y_r))

endmodule
